// File: hw/rtl/fobrm_pkg.sv
// ----------------------------------------------------------------------------
// fobrm_pkg
// Shared types and codes for the fixed-offset byte rule matcher.
// ----------------------------------------------------------------------------
package fobrm_pkg;

  typedef enum logic [1:0] {
    FUNC_ADD   = 2'd0,
    FUNC_DATA  = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_NOP   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    KIND_ACCEPT = 2'd0,
    KIND_REJECT = 2'd1,
    KIND_HIT    = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  localparam int ANCHOR_BYTES = 4;

  typedef struct packed {
    logic [7:0]                   offset;
    logic [2:0]                   length;
    logic [ANCHOR_BYTES-1:0][7:0] bytes;
    logic [15:0]                  id;
  } rule_t;

endpackage

// File: hw/rtl/fobrm_ram.sv
// ----------------------------------------------------------------------------
// fobrm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fobrm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/fixed_offset_byte_rule_matcher.sv
// ----------------------------------------------------------------------------
// fixed_offset_byte_rule_matcher
// Anchored byte rule table with payload window and sorted hit report.
//
//   channel  | handshake          | payload
//   in_      | in_valid/in_stall  | func, rule fields, data_byte, end_of_payload
//   out_     | out_valid/out_stall| kind, hit_rule_id, last
//
// Add, clear and non-final payload bytes are each taken in the idle state.
// The final payload byte starts a walk of the rule table: each rule is read
// and its reach checked, then its anchor bytes are compared one by one;
// passes over the hit list then emit the distinct hit ids in ascending
// order, or a none result with no hit; input stalls for the whole walk.
// Synchronous active-low reset clears rule count, byte count and control.
// Output stall holds the result register and stalls input behind it.
// ----------------------------------------------------------------------------
module fixed_offset_byte_rule_matcher
  import fobrm_pkg::*;
#(
  parameter int MAX_RULES    = 64,
  parameter int WINDOW_BYTES = 256,
  parameter int MAX_ANCHOR   = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [7:0]  in_rule_offset,
  input  logic [2:0]  in_rule_length,
  input  logic [7:0]  in_rule_byte_a,
  input  logic [7:0]  in_rule_byte_b,
  input  logic [7:0]  in_rule_byte_c,
  input  logic [7:0]  in_rule_byte_d,
  input  logic [15:0] in_new_rule_id,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_payload,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [15:0] out_hit_rule_id,
  output logic        out_last
);

  localparam int IDX_W  = MAX_RULES > 1 ? $clog2(MAX_RULES) : 1;
  localparam int CNT_W  = $clog2(MAX_RULES + 1);
  localparam int WIN_AW = WINDOW_BYTES > 1 ? $clog2(WINDOW_BYTES) : 1;
  localparam int SEEN_W = $clog2(WINDOW_BYTES + 1);
  localparam int CMP_W  = (SEEN_W > 9 ? SEEN_W : 9) + 1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RULE_RD, ST_RULE_CHK, ST_BYTE_CHK, ST_SEL_START,
    ST_HIT_RD, ST_HIT_CHK, ST_PASS_END, ST_EMIT_MID, ST_EMIT_FIN, ST_EMIT_NONE
  } state_t;

  state_t            state_r;
  logic [CNT_W-1:0]  rule_count_r;
  logic [SEEN_W-1:0] bytes_seen_r;
  logic [IDX_W-1:0]  ridx_r;
  logic [1:0]        bi_r;
  logic [CNT_W-1:0]  nhit_r;
  logic [IDX_W-1:0]  hidx_r;
  logic              have_last_r;
  logic [15:0]       last_id_r;
  logic              found_r;
  logic [15:0]       best_id_r;
  logic [15:0]       pend_id_r;
  logic              pend_v_r;
  logic              out_valid_r;
  kind_t             out_kind_r;
  logic [15:0]       out_id_r;
  logic              out_last_r;

  logic              in_acc;
  logic              out_free;
  logic              add_ok;
  rule_t             new_rule;
  rule_t             rule_q;
  logic [7:0]        win_q;
  logic [15:0]       hit_q;
  logic              rule_we;
  logic              rule_re;
  logic              win_we;
  logic              win_re;
  logic [WIN_AW-1:0] win_raddr;
  logic [CMP_W-1:0]  win_sum;
  logic              hit_we;
  logic              hit_re;
  logic [CMP_W-1:0]  rule_reach;
  logic              byte_eq;
  logic              byte_last;
  logic              rule_done;
  logic              hit_done;
  logic              better;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign in_acc    = in_valid && !in_stall;

  assign add_ok = (in_rule_length != 3'd0) && (in_rule_length <= 3'(MAX_ANCHOR))
               && (CMP_W'(in_rule_offset) + CMP_W'(in_rule_length) <= CMP_W'(WINDOW_BYTES))
               && (rule_count_r < CNT_W'(MAX_RULES));

  always_comb begin
    new_rule.offset   = in_rule_offset;
    new_rule.length   = in_rule_length;
    new_rule.bytes[0] = in_rule_byte_a;
    new_rule.bytes[1] = in_rule_byte_b;
    new_rule.bytes[2] = in_rule_byte_c;
    new_rule.bytes[3] = in_rule_byte_d;
    new_rule.id       = in_new_rule_id;
  end

  assign rule_we = in_acc && (in_func == FUNC_ADD) && add_ok;
  assign rule_re = (state_r == ST_RULE_RD);
  assign win_we  = in_acc && (in_func == FUNC_DATA) && (bytes_seen_r < SEEN_W'(WINDOW_BYTES));
  assign win_re  = (state_r == ST_RULE_CHK) || (state_r == ST_BYTE_CHK);
  assign hit_re  = (state_r == ST_HIT_RD);

  assign rule_reach = CMP_W'(rule_q.offset) + CMP_W'(rule_q.length);
  assign byte_eq    = (win_q == rule_q.bytes[bi_r]);
  assign byte_last  = (3'(bi_r) + 3'd1 == rule_q.length);
  assign hit_we     = (state_r == ST_BYTE_CHK) && byte_eq && byte_last;
  assign rule_done  = (CNT_W'(ridx_r) + CNT_W'(1) == rule_count_r);
  assign hit_done   = (CNT_W'(hidx_r) + CNT_W'(1) == nhit_r);
  assign better     = (!have_last_r || (hit_q > last_id_r)) && (!found_r || (hit_q < best_id_r));

  always_comb begin
    if (state_r == ST_RULE_CHK) begin
      win_sum = CMP_W'(rule_q.offset);
    end else begin
      win_sum = CMP_W'(rule_q.offset) + CMP_W'(bi_r) + CMP_W'(1);
    end
    win_raddr = win_sum[WIN_AW-1:0];
  end

  fobrm_ram #(.WIDTH($bits(rule_t)), .DEPTH(MAX_RULES)) u_rule_ram (
    .clk   (clk),
    .we    (rule_we),
    .waddr (rule_count_r[IDX_W-1:0]),
    .wdata (new_rule),
    .re    (rule_re),
    .raddr (ridx_r),
    .rdata (rule_q)
  );

  fobrm_ram #(.WIDTH(8), .DEPTH(WINDOW_BYTES)) u_win_ram (
    .clk   (clk),
    .we    (win_we),
    .waddr (bytes_seen_r[WIN_AW-1:0]),
    .wdata (in_data_byte),
    .re    (win_re),
    .raddr (win_raddr),
    .rdata (win_q)
  );

  fobrm_ram #(.WIDTH(16), .DEPTH(MAX_RULES)) u_hit_ram (
    .clk   (clk),
    .we    (hit_we),
    .waddr (nhit_r[IDX_W-1:0]),
    .wdata (rule_q.id),
    .re    (hit_re),
    .raddr (hidx_r),
    .rdata (hit_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      rule_count_r <= '0;
      bytes_seen_r <= '0;
      out_valid_r  <= 1'b0;
      ridx_r       <= '0;
      bi_r         <= '0;
      nhit_r       <= '0;
      hidx_r       <= '0;
      have_last_r  <= 1'b0;
      found_r      <= 1'b0;
      pend_v_r     <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            case (in_func)
              FUNC_ADD: begin
                if (add_ok) begin
                  rule_count_r <= rule_count_r + CNT_W'(1);
                end
                out_valid_r <= 1'b1;
                out_kind_r  <= add_ok ? KIND_ACCEPT : KIND_REJECT;
                out_id_r    <= '0;
                out_last_r  <= 1'b1;
              end
              FUNC_DATA: begin
                if (win_we) begin
                  bytes_seen_r <= bytes_seen_r + SEEN_W'(1);
                end
                if (in_end_of_payload) begin
                  ridx_r <= '0;
                  nhit_r <= '0;
                  state_r <= (rule_count_r == '0) ? ST_SEL_START : ST_RULE_RD;
                end
              end
              FUNC_CLEAR: begin
                rule_count_r <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        ST_RULE_RD: begin
          state_r <= ST_RULE_CHK;
        end
        ST_RULE_CHK: begin
          bi_r <= '0;
          if (rule_reach > CMP_W'(bytes_seen_r)) begin
            ridx_r  <= ridx_r + IDX_W'(1);
            state_r <= rule_done ? ST_SEL_START : ST_RULE_RD;
          end else begin
            state_r <= ST_BYTE_CHK;
          end
        end
        ST_BYTE_CHK: begin
          if (!byte_eq || byte_last) begin
            if (hit_we) begin
              nhit_r <= nhit_r + CNT_W'(1);
            end
            ridx_r  <= ridx_r + IDX_W'(1);
            state_r <= rule_done ? ST_SEL_START : ST_RULE_RD;
          end else begin
            bi_r <= bi_r + 2'd1;
          end
        end
        ST_SEL_START: begin
          have_last_r <= 1'b0;
          found_r     <= 1'b0;
          pend_v_r    <= 1'b0;
          hidx_r      <= '0;
          state_r     <= (nhit_r == '0) ? ST_EMIT_NONE : ST_HIT_RD;
        end
        ST_HIT_RD: begin
          state_r <= ST_HIT_CHK;
        end
        ST_HIT_CHK: begin
          if (better) begin
            found_r   <= 1'b1;
            best_id_r <= hit_q;
          end
          hidx_r  <= hidx_r + IDX_W'(1);
          state_r <= hit_done ? ST_PASS_END : ST_HIT_RD;
        end
        ST_PASS_END: begin
          hidx_r  <= '0;
          found_r <= 1'b0;
          if (found_r) begin
            last_id_r   <= best_id_r;
            have_last_r <= 1'b1;
            if (pend_v_r) begin
              state_r <= ST_EMIT_MID;
            end else begin
              pend_id_r <= best_id_r;
              pend_v_r  <= 1'b1;
              state_r   <= ST_HIT_RD;
            end
          end else begin
            state_r <= ST_EMIT_FIN;
          end
        end
        ST_EMIT_MID: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= KIND_HIT;
            out_id_r    <= pend_id_r;
            out_last_r  <= 1'b0;
            pend_id_r   <= last_id_r;
            state_r     <= ST_HIT_RD;
          end
        end
        ST_EMIT_FIN: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_kind_r   <= KIND_HIT;
            out_id_r     <= pend_id_r;
            out_last_r   <= 1'b1;
            bytes_seen_r <= '0;
            state_r      <= ST_IDLE;
          end
        end
        ST_EMIT_NONE: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_kind_r   <= KIND_NONE;
            out_id_r     <= '0;
            out_last_r   <= 1'b1;
            bytes_seen_r <= '0;
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_hit_rule_id = out_id_r;
  assign out_last        = out_last_r;

endmodule

// File: hw/rtl/fobrm_checker.sv
// ----------------------------------------------------------------------------
// fobrm_checker
// Port-level checks for the fixed-offset byte rule matcher.
// ----------------------------------------------------------------------------
module fobrm_checker
  import fobrm_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  in_func,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_kind,
  input logic [15:0] out_hit_rule_id,
  input logic        out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) && $stable(out_hit_rule_id))
    else $error("stalled transaction changed");

  a_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_HIT |-> out_hit_rule_id == 16'd0)
    else $error("nonzero id on non-hit transaction");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_HIT |-> out_last)
    else $error("single result without last");

  a_add_reply: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_func == FUNC_ADD |=>
      out_valid && (out_kind == KIND_ACCEPT || out_kind == KIND_REJECT))
    else $error("add without reply");

endmodule

bind fixed_offset_byte_rule_matcher fobrm_checker u_fobrm_checker (.*);
